// ----- hw/rtl/nlf_pkg.sv -----
// ============================================================================
// nlf_pkg: shared types and constants for the newline line framer
// Sequencer state type, request kinds and fixed field widths.
// ============================================================================
`default_nettype none

package nlf_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAXLEN_W  = 6;
  localparam int OUT_USR_W = 2;

  localparam logic [BYTE_W-1:0]   NEWLINE_CODE  = 8'h0A;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET  = 6'd63;

  // request kind carried on s_tuser
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // bit positions in m_tuser
  localparam int USR_EMPTY = 0;
  localparam int USR_TRUNC = 1;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nlf_ram.sv -----
// ============================================================================
// nlf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module nlf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/newline_line_framer_top.sv -----
// ============================================================================
// newline_line_framer_top: newline-delimited line framer
// Collects bytes into a line buffer; on newline, plays the line back one
// byte per result, cut to max_out_len, with last/empty/truncated marks.
// ============================================================================
//
//  channel   dir  handshake             payload
//  --------  ---  --------------------  -----------------------------------
//  s_*       in   s_tvalid / s_tready   s_tdata = in_byte, s_tuser = func
//  m_*       out  m_tvalid / m_tready   m_tdata = out_byte, m_tlast = last,
//                                       m_tuser = {truncated, empty_line}
//  cfg_*     in   cfg_we (no stall)     cfg_wdata = max_out_len
//
//  Byte and flush requests keep the framer in idle, where s_tready is high.
//  A newline starts playback, one result per delivered byte (one result for an
//  empty line): the line buffer RAM has one read port and a registered read,
//  and the next byte is fetched on the same edge that the current one leaves.
//  While a line drains, s_tready is low; m_tready stalls just hold the result.
//  Reset (rst, synchronous) empties the buffer and sets max_out_len to 63;
//  buffer contents are not cleared, only the fill count.
// ============================================================================
`default_nettype none

module newline_line_framer_top
  import nlf_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
  input  wire logic                 s_tuser,   // [0] func
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
  output logic                      m_tlast,   // last
  output logic      [OUT_USR_W-1:0] m_tuser,   // [0] empty_line, [1] truncated
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [MAXLEN_W-1:0]  cfg_wdata  // max_out_len
);

  localparam int FW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CMPW = (FW > MAXLEN_W) ? FW : MAXLEN_W;
  localparam logic [FW-1:0] FILL_TOP = FW'(LINE_DEPTH - 1);

  state_t state, state_next;

  logic [MAXLEN_W-1:0] max_out_len;
  logic [FW-1:0]       fill;       // bytes held, always below LINE_DEPTH
  logic [FW-1:0]       idx;        // index of the byte on the output
  logic [FW-1:0]       last_idx;   // index of the final delivered byte of the line
  logic                empty_flag;
  logic                trunc_flag;

  logic              s_acc, m_acc;
  logic              byte_acc, nl_acc;
  logic              is_last;
  logic [CMPW-1:0]   fill_ext, max_ext, copy_len;
  logic [FW-1:0]     idx_inc;

  logic              wr_en, rd_en;
  logic [FW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign byte_acc = s_acc && (s_tuser == FUNC_BYTE) && (s_tdata != NEWLINE_CODE);
  assign nl_acc   = s_acc && (s_tuser == FUNC_BYTE) && (s_tdata == NEWLINE_CODE);

  // length compare: delivered count is min(fill, max_out_len)
  assign fill_ext = CMPW'(fill);
  assign max_ext  = CMPW'(max_out_len);
  assign copy_len = (fill_ext < max_ext) ? fill_ext : max_ext;
  assign idx_inc  = FW'(idx + 1'b1);
  assign is_last  = empty_flag || (idx == last_idx);

  // line buffer
  assign wr_en = byte_acc;

  nlf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      max_out_len <= MAXLEN_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_out_len <= cfg_wdata;
      end
      if (s_acc) begin
        // flush, newline and a full buffer all restart collection
        if (byte_acc && (fill != FILL_TOP)) begin
          fill <= FW'(fill + 1'b1);
        end else begin
          fill <= '0;
        end
      end
    end
  end

  // line descriptor, latched at the newline
  always_ff @(posedge clk) begin
    if (nl_acc) begin
      idx        <= '0;
      last_idx   <= FW'(copy_len - 1'b1);
      empty_flag <= (copy_len == '0);
      trunc_flag <= (fill_ext > max_ext);
    end else if (m_acc) begin
      idx <= idx_inc;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (nl_acc) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (m_acc && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and read fetch: byte 0 is fetched on the newline, each later
  // byte on the edge that takes the previous one
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        // ready is high here, so a valid newline is taken this edge
        rd_en    = s_tvalid && (s_tuser == FUNC_BYTE) && (s_tdata == NEWLINE_CODE);
      end
      ST_SEND: begin
        m_tvalid = 1'b1;
        rd_en    = m_acc && !is_last;
        rd_addr  = idx_inc;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign m_tdata            = empty_flag ? '0 : rd_data;
  assign m_tlast            = is_last;
  assign m_tuser[USR_EMPTY] = empty_flag;
  assign m_tuser[USR_TRUNC] = trunc_flag && is_last;

endmodule

`default_nettype wire

// ----- hw/rtl/nlf_checker.sv -----
// ============================================================================
// nlf_checker: port-level checks for the newline line framer
// Watches the top-level ports; bound to newline_line_framer_top.
// ============================================================================
`default_nettype none

module nlf_checker
  import nlf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [BYTE_W-1:0]    m_tdata,
  input wire logic                 m_tlast,
  input wire logic [OUT_USR_W-1:0] m_tuser
);

  // nothing to deliver right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input is blocked while a line drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a line is draining");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("result changed under stall");

  // an empty line is a single, final result
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USR_EMPTY]) |-> m_tlast)
    else $error("empty-line result not marked last");

  // end of a line returns to accepting input
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("framer not idle after final result");

endmodule

bind newline_line_framer_top nlf_checker u_nlf_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for newline_line_framer_top
// Streams byte and flush requests into the framer and checks every result
// against an in-bench line predictor. Directed table first, then random lines.
// ============================================================================

module tb
  import nlf_pkg::*;
();

  localparam int LINE_DEPTH  = 64;
  localparam int LB_AW       = $clog2(LINE_DEPTH);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_PLAN      = 24;

  // one delivered result of a line
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              empty_line;
    logic              truncated;
  } line_beat_t;

  localparam line_beat_t NO_BEAT = '0;

  typedef enum logic {
    ROW_REQ,  // send a request, reps times, byte incrementing
    ROW_CFG   // write max_out_len from data
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              fn;
    logic [BYTE_W-1:0] data;
    logic [6:0]        reps;
    bit                typed;  // want holds the single expected result
    line_beat_t        want;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic                 s_tuser   = FUNC_BYTE;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 m_tlast;
  logic [OUT_USR_W-1:0] m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [MAXLEN_W-1:0]  cfg_wdata = '0;

  // predictor state
  logic [BYTE_W-1:0]   line_buf [LINE_DEPTH];
  int unsigned         line_fill = 0;
  logic [MAXLEN_W-1:0] max_len   = MAXLEN_RESET;

  line_beat_t  line_beats_due [$];
  int          mismatch_cnt = 0;
  int          idle_pct     = 32;
  int unsigned cycle_cnt    = 0;

  // directed table; byte runs are chosen so that no newline appears inside
  plan_row_t plan [N_PLAN] = '{
    // empty line straight after reset
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{ROW_REQ, FUNC_BYTE,  8'h41, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
    // byte extremes
    '{ROW_REQ, FUNC_BYTE,  8'h00, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'hFF, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b0, NO_BEAT},
    // flush drops a partial line; a flush carrying a newline byte is still a flush
    '{ROW_REQ, FUNC_BYTE,  8'h55, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_FLUSH, 8'hFF, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_FLUSH, 8'h0A, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    // buffer fills with no newline: 80..BF, then everything is dropped
    '{ROW_REQ, FUNC_BYTE,  8'h80, 7'd64, 1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    // longest line that fits, at the widest limit: 10..4E
    '{ROW_REQ, FUNC_BYTE,  8'h10, 7'd63, 1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b0, NO_BEAT},
    // limit 0: any non-empty line comes out empty and cut
    '{ROW_CFG, FUNC_BYTE,  8'd0,  7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h33, 7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    // limit 1
    '{ROW_CFG, FUNC_BYTE,  8'd1,  7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h12, 7'd2,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b1, '{8'h12, 1'b1, 1'b0, 1'b1}},
    // limit 5 against a 7-byte line: C0..C6
    '{ROW_CFG, FUNC_BYTE,  8'd5,  7'd1,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'hC0, 7'd7,  1'b0, NO_BEAT},
    '{ROW_REQ, FUNC_BYTE,  8'h0A, 7'd1,  1'b0, NO_BEAT}
  };

  newline_line_framer_top #(
    .LINE_DEPTH(LINE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Line predictor: updates the buffer model for one accepted request and
  // returns the results it causes (none for a stored byte or a flush).
  function automatic void frame_request(input logic fn, input logic [BYTE_W-1:0] b,
                                        ref line_beat_t beats[$]);
    int unsigned len;
    int unsigned n;
    logic        cut;
    line_beat_t  beat;
    beats.delete();
    if (fn == FUNC_FLUSH) begin
      line_fill = 0;
      return;
    end
    if (b != NEWLINE_CODE) begin
      line_buf[LB_AW'(line_fill)] = b;
      line_fill++;
      // full buffer with no newline: drop it all
      if (line_fill >= LINE_DEPTH) line_fill = 0;
      return;
    end
    len       = line_fill;
    n         = (len < max_len) ? len : max_len;
    cut       = (len > max_len);
    line_fill = 0;
    if (n == 0) begin
      beats.push_back('{8'h00, 1'b1, 1'b1, cut});
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      beat.out_byte   = line_buf[LB_AW'(i)];
      beat.last       = (i + 1 == n);
      beat.empty_line = 1'b0;
      beat.truncated  = (i + 1 == n) && cut;
      beats.push_back(beat);
    end
  endfunction

  // Drive one request, with random idle cycles ahead of it. s_tvalid is left
  // high on return; the caller sends again or lowers it in the same step.
  task automatic send_request(input logic fn, input logic [BYTE_W-1:0] b,
                              input bit typed, input line_beat_t want);
    line_beat_t beats [$];
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frame_request(fn, b, beats);
    if (typed) line_beats_due.push_back(want);
    else foreach (beats[i]) line_beats_due.push_back(beats[i]);
  endtask

  // Register write only once the framer has gone quiet.
  task automatic write_max_len(input logic [MAXLEN_W-1:0] v);
    s_tvalid <= 1'b0;
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // let the sequencer settle back to idle
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_len    = v;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result side: random backpressure, same duty as the request side
  always @(posedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin : result_check
    line_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (line_beats_due.size() == 0) begin
        $error("unexpected result: out_byte %0h last %0b user %0b", m_tdata, m_tlast, m_tuser);
        mismatch_cnt++;
      end else begin
        want = line_beats_due.pop_front();
        check_field("out_byte", want.out_byte, m_tdata);
        check_field("last", want.last, m_tlast);
        check_field("empty_line", want.empty_line, m_tuser[USR_EMPTY]);
        check_field("truncated", want.truncated, m_tuser[USR_TRUNC]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          sent;
    int          budget;
    int          pick;
    int          len;
    logic [7:0]  b;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_max_len(plan[r].data[MAXLEN_W-1:0]);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          send_request(plan[r].fn, plan[r].data + k[7:0], plan[r].typed, plan[r].want);
      end
    end

    // random lines over several limits; phase 2 runs with no idling at all
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_max_len(MAXLEN_RESET);
        1:       write_max_len('0);
        4:       write_max_len(6'd1);
        default: write_max_len(MAXLEN_W'($urandom_range(2, 62)));
      endcase
      idle_pct = (ph == 2) ? 0 : 32;
      budget   = (ph == 2) ? 12 : 3;
      sent = 0;
      while (sent < budget) begin
        pick = $urandom_range(99);
        if (pick < 88) begin
          // short lines; cut whenever the limit is below their length
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            do b = 8'($urandom_range(255)); while (b == NEWLINE_CODE);
            send_request(FUNC_BYTE, b, 1'b0, NO_BEAT);
          end
          sent += len + 1;
          // broken line: partial bytes dropped by a flush
          if (pick >= 80) send_request(FUNC_FLUSH, BYTE_W'($urandom_range(255)), 1'b0, NO_BEAT);
          else send_request(FUNC_BYTE, NEWLINE_CODE, 1'b0, NO_BEAT);
        end else begin
          // noise: any kind, any byte
          send_request(1'($urandom_range(1)), BYTE_W'($urandom_range(255)), 1'b0, NO_BEAT);
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
